// File: hw/rtl/gel_pkg.sv
// ----------------------------------------------------------------------------
// gel_pkg: shared constants for the generalised ellipse radius unit
// field widths, register indexes, pipeline latencies and the exp2 rom
// ----------------------------------------------------------------------------
package gel_pkg;

  localparam int IN_W      = 20;
  localparam int OUT_W     = 32;
  localparam int FRAC_BITS = 8;
  localparam int CFG_W     = 25;
  localparam int CFG_IDX_W = 3;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_COS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IAR = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EXP = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_IEX = 3'd4;

  // fraction bits of the two coordinates and of the log-domain sum
  localparam int FB_X   = FRAC_BITS + 16;
  localparam int FB_Y   = FRAC_BITS + 32;
  localparam int FB_SUM = 30;

  localparam int LOG_LAT  = 18;
  localparam int EXP_LAT  = 16;
  localparam int PIPE_LAT = 80;

  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

  // entry k is floor(sqrt(entry(k-1) * 2^30)), entry 0 being 2.0 in q1.30
  function automatic logic [30:0] exp_rom_entry(input int k);
    logic [63:0] e;
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bt;
    e = 64'd1 << 31;
    for (int j = 1; j <= k; j++) begin
      v   = e << 30;
      res = 64'd0;
      bt  = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
        if (v >= res + bt) begin
          v   = v - (res + bt);
          res = (res >> 1) + bt;
        end else begin
          res = res >> 1;
        end
        bt = bt >> 2;
      end
      e = res;
    end
    return e[30:0];
  endfunction

  localparam logic [30:0] EXP_ROM [1:16] = '{
    exp_rom_entry(1),  exp_rom_entry(2),  exp_rom_entry(3),  exp_rom_entry(4),
    exp_rom_entry(5),  exp_rom_entry(6),  exp_rom_entry(7),  exp_rom_entry(8),
    exp_rom_entry(9),  exp_rom_entry(10), exp_rom_entry(11), exp_rom_entry(12),
    exp_rom_entry(13), exp_rom_entry(14), exp_rom_entry(15), exp_rom_entry(16)
  };

endpackage

// File: hw/rtl/generalized_ellipse_radius_unit.sv
// ----------------------------------------------------------------------------
// generalized_ellipse_radius_unit: generalised elliptical radius per pixel
// rotates (dx, dy), scales the minor axis, and returns (|x|^p + |y|^p)^(1/p)
// in a base-2 log domain, saturating on overflow
// ----------------------------------------------------------------------------
//
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------------------------
//  input    | start && !busy        | in_delta_x, in_delta_y (signed q12.8)
//  result   | out_valid, one cycle  | out_radius (q24.8), out_saturated
//  config   | cfg_we                | cfg_idx, cfg_wdata
//
//  one transaction may enter every cycle; the result of each passes through
//  the chain of two log2 and two exp2 units of 16 squaring or product stages
//  each plus the arithmetic stages around them. busy is high only while
//  rst_n is low. reset clears the valid bits
//  and the config registers; the datapath registers carry no reset. there is
//  no back-pressure on the result side, so nothing ever stalls.
// ----------------------------------------------------------------------------
module generalized_ellipse_radius_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [gel_pkg::IN_W-1:0]    in_delta_x,
  input  logic signed [gel_pkg::IN_W-1:0]    in_delta_y,
  input  logic                               cfg_we,
  input  logic [gel_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [gel_pkg::CFG_W-1:0]          cfg_wdata,
  output logic                               out_valid,
  output logic [gel_pkg::OUT_W-1:0]          out_radius,
  output logic                               out_saturated
);
  import gel_pkg::*;

  // config registers
  logic signed [17:0] cos_r, sin_r;
  logic [24:0]        iar_r;
  logic [15:0]        p_r;
  logic [14:0]        ie_r;

  logic accept;

  // stage a: rotation products
  logic               vld_a_r;
  logic signed [37:0] xc_a_r, ys_a_r, yc_a_r, xs_a_r;
  // stage b: rotated coordinates, magnitudes
  logic               vld_b_r;
  logic signed [38:0] x_b, y_b;
  logic [37:0]        ax_b_r, ay_b_r;
  // stage c: minor axis scaling, split in two partial products
  logic               vld_c_r;
  logic [43:0]        lo_c_r, hi_c_r;
  logic [37:0]        ax_c_r;
  // stage d: scaled minor axis
  logic               vld_d_r;
  logic [63:0]        ay_d_nxt, ay_d_r;
  logic [37:0]        ax_d_r;
  logic               az_d_r, bz_d_r;
  // log units on both coordinates
  logic               vld_la, vld_lb;
  logic [5:0]         pos_la, pos_lb;
  logic [15:0]        frac_la, frac_lb;
  logic [1:0]         zdly_r [LOG_LAT];
  // stage e: p * log2
  logic               vld_e_r;
  logic signed [6:0]  ip_la, ip_lb;
  logic signed [22:0] l_a, l_b;
  logic signed [39:0] pa_e_r, pb_e_r;
  logic               az_e_r, bz_e_r;
  // stage f: max and distance of the two powers
  logic               vld_f_r;
  logic signed [27:0] ea_f, eb_f;
  logic signed [28:0] diff_f;
  logic signed [27:0] mx_f_r;
  logic [27:0]        d_f_r;
  logic               one_f_r, none_f_r;
  // stage g: split of -d into shift and fraction
  logic               vld_g_r;
  logic [15:0]        fr_g_r;
  logic [12:0]        sh_g_r;
  logic [28:0]        dsum_g;
  logic signed [27:0] mx_g_r;
  logic               one_g_r, none_g_r;
  logic [42:0]        gdly_r [EXP_LAT];
  // first exp unit
  logic               vld_x1;
  logic [30:0]        m_x1;
  // stage h: 1 + 2^-d
  logic               vld_h_r;
  logic [12:0]        sh_h;
  logic [31:0]        fterm_h, v3_h_r;
  logic signed [27:0] mx_h_r;
  logic               one_h_r, none_h_r;
  logic [29:0]        hdly_r [LOG_LAT];
  // sum log unit
  logic               vld_l3;
  logic [5:0]         pos_l3;
  logic [15:0]        frac_l3;
  // stage i: log-domain sum
  logic               vld_i_r;
  logic signed [6:0]  ip_l3;
  logic signed [22:0] l_s;
  logic signed [28:0] s_i_r;
  logic               none_i_r;
  // stage j: s / p
  logic               vld_j_r;
  logic signed [44:0] pr_j_r;
  logic               none_j_r;
  // stage k: integer and fraction of the root
  localparam logic signed [33:0] T_OFS = 34'(FRAC_BITS) <<< 16;
  logic               vld_k_r;
  logic signed [33:0] t_k;
  logic signed [17:0] ip_k_r;
  logic [15:0]        fp_k_r;
  logic               none_k_r;
  logic [18:0]        kdly_r [EXP_LAT];
  // second exp unit and output stage
  logic               vld_x2;
  logic [30:0]        m_x2;
  logic signed [17:0] ip_o;
  logic               none_o;
  logic [31:0]        rad_nxt;
  logic               sat_nxt;

  assign busy   = !rst_n;
  assign accept = start && !busy;

  // config write port, index beyond the list is dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cos_r <= 18'sd65536;
      sin_r <= 18'sd0;
      iar_r <= 25'd65536;
      p_r   <= 16'd8192;
      ie_r  <= 15'd2048;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_COS: cos_r <= cfg_wdata[17:0];
        REG_SIN: sin_r <= cfg_wdata[17:0];
        REG_IAR: iar_r <= cfg_wdata[24:0];
        REG_EXP: p_r   <= cfg_wdata[15:0];
        REG_IEX: ie_r  <= cfg_wdata[14:0];
        default: ;
      endcase
    end
  end

  // valid bits of the top-level stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r   <= 1'b0;
      vld_b_r   <= 1'b0;
      vld_c_r   <= 1'b0;
      vld_d_r   <= 1'b0;
      vld_e_r   <= 1'b0;
      vld_f_r   <= 1'b0;
      vld_g_r   <= 1'b0;
      vld_h_r   <= 1'b0;
      vld_i_r   <= 1'b0;
      vld_j_r   <= 1'b0;
      vld_k_r   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      vld_a_r   <= accept;
      vld_b_r   <= vld_a_r;
      vld_c_r   <= vld_b_r;
      vld_d_r   <= vld_c_r;
      vld_e_r   <= vld_la;
      vld_f_r   <= vld_e_r;
      vld_g_r   <= vld_f_r;
      vld_h_r   <= vld_x1;
      vld_i_r   <= vld_l3;
      vld_j_r   <= vld_i_r;
      vld_k_r   <= vld_j_r;
      out_valid <= vld_x2;
    end
  end

  // stages a to d: rotation, magnitudes and minor axis scaling
  assign x_b      = 39'(xc_a_r) + 39'(ys_a_r);
  assign y_b      = 39'(yc_a_r) - 39'(xs_a_r);
  assign ay_d_nxt = 64'(lo_c_r) + (64'(hi_c_r) << 19);

  always_ff @(posedge clk) begin
    xc_a_r <= 38'(in_delta_x) * 38'(cos_r);
    ys_a_r <= 38'(in_delta_y) * 38'(sin_r);
    yc_a_r <= 38'(in_delta_y) * 38'(cos_r);
    xs_a_r <= 38'(in_delta_x) * 38'(sin_r);
    ax_b_r <= x_b[38] ? 38'(-x_b) : x_b[37:0];
    ay_b_r <= y_b[38] ? 38'(-y_b) : y_b[37:0];
    lo_c_r <= 44'(ay_b_r[18:0]) * 44'(iar_r);
    hi_c_r <= 44'(ay_b_r[37:19]) * 44'(iar_r);
    ax_c_r <= ax_b_r;
    ay_d_r <= ay_d_nxt;
    ax_d_r <= ax_c_r;
    az_d_r <= (ax_c_r == 38'd0);
    bz_d_r <= (ay_d_nxt == 64'd0);
  end

  gel_log2 u_log_x (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (vld_d_r),
    .v_i    ({26'd0, ax_d_r}),
    .vld_o  (vld_la),
    .pos_o  (pos_la),
    .frac_o (frac_la)
  );

  gel_log2 u_log_y (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (vld_d_r),
    .v_i    (ay_d_r),
    .vld_o  (vld_lb),
    .pos_o  (pos_lb),
    .frac_o (frac_lb)
  );

  // zero flags ride alongside the log units
  always_ff @(posedge clk) begin
    zdly_r[0] <= {az_d_r, bz_d_r};
    for (int i = 1; i < LOG_LAT; i++) zdly_r[i] <= zdly_r[i-1];
  end

  // stage e: signed log value, integer part over the 16 fraction bits
  assign ip_la = $signed({1'b0, pos_la}) - 7'(FB_X);
  assign ip_lb = $signed({1'b0, pos_lb}) - 7'(FB_Y);
  assign l_a   = {ip_la, frac_la};
  assign l_b   = {ip_lb, frac_lb};

  always_ff @(posedge clk) begin
    pa_e_r <= 40'(l_a) * 40'($signed({1'b0, p_r}));
    pb_e_r <= 40'(l_b) * 40'($signed({1'b0, p_r}));
    az_e_r <= zdly_r[LOG_LAT-1][1];
    bz_e_r <= zdly_r[LOG_LAT-1][0];
  end

  // stage f: floor by 4096 is the top bits; a lone term passes through
  assign ea_f   = pa_e_r[39:12];
  assign eb_f   = pb_e_r[39:12];
  assign diff_f = 29'(ea_f) - 29'(eb_f);

  always_ff @(posedge clk) begin
    none_f_r <= az_e_r && bz_e_r;
    one_f_r  <= az_e_r ^ bz_e_r;
    if (az_e_r) begin
      mx_f_r <= eb_f;
    end else if (bz_e_r) begin
      mx_f_r <= ea_f;
    end else begin
      mx_f_r <= diff_f[28] ? eb_f : ea_f;
    end
    d_f_r <= diff_f[28] ? 28'(-diff_f) : diff_f[27:0];
  end

  // stage g: -d = -sh * 65536 + fraction
  assign dsum_g = {1'b0, d_f_r} + 29'd65535;

  always_ff @(posedge clk) begin
    fr_g_r   <= 16'd0 - d_f_r[15:0];
    sh_g_r   <= dsum_g[28:16];
    mx_g_r   <= mx_f_r;
    one_g_r  <= one_f_r;
    none_g_r <= none_f_r;
  end

  gel_exp2 u_exp_sum (
    .clk   (clk),
    .rst_n (rst_n),
    .vld_i (vld_g_r),
    .f_i   (fr_g_r),
    .vld_o (vld_x1),
    .m_o   (m_x1)
  );

  always_ff @(posedge clk) begin
    gdly_r[0] <= {mx_g_r, sh_g_r, one_g_r, none_g_r};
    for (int i = 1; i < EXP_LAT; i++) gdly_r[i] <= gdly_r[i-1];
  end

  // stage h: 2^-d shifted down, a shift past the mantissa leaves nothing
  assign sh_h    = gdly_r[EXP_LAT-1][14:2];
  assign fterm_h = (sh_h >= 13'd31) ? 32'd0 : (32'(m_x1) >> sh_h[4:0]);

  always_ff @(posedge clk) begin
    v3_h_r   <= 32'(ONE_Q30) + fterm_h;
    mx_h_r   <= gdly_r[EXP_LAT-1][42:15];
    one_h_r  <= gdly_r[EXP_LAT-1][1];
    none_h_r <= gdly_r[EXP_LAT-1][0];
  end

  gel_log2 u_log_sum (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (vld_h_r),
    .v_i    ({32'd0, v3_h_r}),
    .vld_o  (vld_l3),
    .pos_o  (pos_l3),
    .frac_o (frac_l3)
  );

  always_ff @(posedge clk) begin
    hdly_r[0] <= {mx_h_r, one_h_r, none_h_r};
    for (int i = 1; i < LOG_LAT; i++) hdly_r[i] <= hdly_r[i-1];
  end

  // stage i: log-domain sum, the correction is left out when only one term exists
  assign ip_l3 = $signed({1'b0, pos_l3}) - 7'(FB_SUM);
  assign l_s   = {ip_l3, frac_l3};

  always_ff @(posedge clk) begin
    if (hdly_r[LOG_LAT-1][1]) begin
      s_i_r <= 29'($signed(hdly_r[LOG_LAT-1][29:2]));
    end else begin
      s_i_r <= 29'($signed(hdly_r[LOG_LAT-1][29:2])) + 29'(l_s);
    end
    none_i_r <= hdly_r[LOG_LAT-1][0];
  end

  // stage j: times 1/p
  always_ff @(posedge clk) begin
    pr_j_r   <= 45'(s_i_r) * 45'($signed({1'b0, ie_r}));
    none_j_r <= none_i_r;
  end

  // stage k: floor by 4096, add the output fraction bits
  assign t_k = 34'($signed(pr_j_r[44:12])) + T_OFS;

  always_ff @(posedge clk) begin
    ip_k_r   <= t_k[33:16];
    fp_k_r   <= t_k[15:0];
    none_k_r <= none_j_r;
  end

  gel_exp2 u_exp_root (
    .clk   (clk),
    .rst_n (rst_n),
    .vld_i (vld_k_r),
    .f_i   (fp_k_r),
    .vld_o (vld_x2),
    .m_o   (m_x2)
  );

  always_ff @(posedge clk) begin
    kdly_r[0] <= {ip_k_r, none_k_r};
    for (int i = 1; i < EXP_LAT; i++) kdly_r[i] <= kdly_r[i-1];
  end

  // output stage: place the mantissa, saturate past 32 integer bits
  assign ip_o   = kdly_r[EXP_LAT-1][18:1];
  assign none_o = kdly_r[EXP_LAT-1][0];

  always_comb begin
    rad_nxt = 32'd0;
    sat_nxt = 1'b0;
    if (none_o) begin
      rad_nxt = 32'd0;
    end else if (ip_o >= 18'sd32) begin
      rad_nxt = '1;
      sat_nxt = 1'b1;
    end else if (ip_o == 18'sd31) begin
      rad_nxt = {m_x2, 1'b0};
    end else if (ip_o == 18'sd30) begin
      rad_nxt = 32'(m_x2);
    end else if (ip_o[17]) begin
      rad_nxt = 32'd0;
    end else begin
      rad_nxt = 32'(m_x2) >> (5'd30 - ip_o[4:0]);
    end
  end

  always_ff @(posedge clk) begin
    out_radius    <= rad_nxt;
    out_saturated <= sat_nxt;
  end

endmodule

// File: hw/rtl/gel_log2.sv
// ----------------------------------------------------------------------------
// gel_log2: pipelined base-2 logarithm
// msb position plus 16 fraction bits by repeated squaring, one bit a stage
// ----------------------------------------------------------------------------
module gel_log2 (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        vld_i,
  input  logic [63:0] v_i,
  output logic        vld_o,
  output logic [5:0]  pos_o,
  output logic [15:0] frac_o
);
  import gel_pkg::*;

  logic [5:0]  pos_nxt;
  logic [63:0] v0_r;
  logic [93:0] norm;
  logic        vld_r  [0:17];
  logic [5:0]  pos_r  [0:17];
  logic [30:0] m_r    [0:15];
  logic [15:0] frac_r [1:16];

  // priority encoder, highest set bit wins
  always_comb begin
    pos_nxt = 6'd0;
    for (int i = 0; i < 64; i++) begin
      if (v_i[i]) pos_nxt = 6'(i);
    end
  end

  assign norm = {v0_r, 30'd0} >> pos_r[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 18; i++) vld_r[i] <= 1'b0;
    end else begin
      vld_r[0] <= vld_i;
      for (int i = 1; i < 18; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    v0_r     <= v_i;
    pos_r[0] <= pos_nxt;
    m_r[0]   <= norm[30:0];
    for (int i = 1; i < 18; i++) pos_r[i] <= pos_r[i-1];
  end

  for (genvar k = 0; k < 16; k++) begin : g_sq
    logic [61:0] sq;
    logic [15:0] frac_prev;
    assign sq = 62'(m_r[k]) * 62'(m_r[k]);
    if (k == 0) begin : g_first
      assign frac_prev = 16'd0;
    end else begin : g_rest
      assign frac_prev = frac_r[k];
    end
    always_ff @(posedge clk) begin
      frac_r[k+1] <= {frac_prev[14:0], sq[61]};
    end
    if (k < 15) begin : g_m
      always_ff @(posedge clk) begin
        m_r[k+1] <= sq[61] ? sq[61:31] : sq[60:30];
      end
    end
  end

  assign vld_o  = vld_r[17];
  assign pos_o  = pos_r[17];
  assign frac_o = frac_r[16];

endmodule

// File: hw/rtl/gel_exp2.sv
// ----------------------------------------------------------------------------
// gel_exp2: pipelined exp2 of a 16-bit fraction
// one rom product a stage, q1.30 result
// ----------------------------------------------------------------------------
module gel_exp2 (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        vld_i,
  input  logic [15:0] f_i,
  output logic        vld_o,
  output logic [30:0] m_o
);
  import gel_pkg::*;

  logic        vld_r [1:16];
  logic [30:0] acc_r [1:16];
  logic [15:0] f_r   [1:15];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 1; i <= 16; i++) vld_r[i] <= 1'b0;
    end else begin
      vld_r[1] <= vld_i;
      for (int i = 2; i <= 16; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  for (genvar k = 1; k <= 16; k++) begin : g_stage
    logic [30:0] acc_in;
    logic [15:0] f_in;
    logic [61:0] prod;
    if (k == 1) begin : g_first
      assign acc_in = ONE_Q30;
      assign f_in   = f_i;
    end else begin : g_rest
      assign acc_in = acc_r[k-1];
      assign f_in   = f_r[k-1];
    end
    assign prod = 62'(acc_in) * 62'(EXP_ROM[k]);
    always_ff @(posedge clk) begin
      acc_r[k] <= f_in[16-k] ? prod[60:30] : acc_in;
    end
    if (k < 16) begin : g_f
      always_ff @(posedge clk) begin
        f_r[k] <= f_in;
      end
    end
  end

  assign vld_o = vld_r[16];
  assign m_o   = acc_r[16];

endmodule

// File: hw/rtl/gel_checker.sv
// ----------------------------------------------------------------------------
// gel_checker: port-level checks of the generalised ellipse radius unit
// fixed latency, saturation code and zero offset behaviour
// ----------------------------------------------------------------------------
module gel_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               start,
  input logic                               busy,
  input logic signed [gel_pkg::IN_W-1:0]    in_delta_x,
  input logic signed [gel_pkg::IN_W-1:0]    in_delta_y,
  input logic                               out_valid,
  input logic [gel_pkg::OUT_W-1:0]          out_radius,
  input logic                               out_saturated
);
  import gel_pkg::*;

  // every result belongs to a transaction taken a fixed time earlier
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, PIPE_LAT))
    else $error("result without a matching transaction");

  // saturation always shows the all-ones radius
  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_saturated) |-> (out_radius == '1))
    else $error("saturated result without full-scale radius");

  // a zero offset gives a zero radius
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(in_delta_x == '0 && in_delta_y == '0, PIPE_LAT))
      |-> (out_radius == '0 && !out_saturated))
    else $error("zero offset gave a nonzero radius");

endmodule

bind generalized_ellipse_radius_unit gel_checker u_gel_checker (.*);

// File: dv/tb_generalized_ellipse_radius_unit.sv
// ----------------------------------------------------------------------------
// tb_generalized_ellipse_radius_unit: self-checking bench for the radius unit
// a directed table under the reset settings, then random pixel offsets over
// several register settings, each result checked against its typed answer
// or a log-domain predictor held in the bench
// ----------------------------------------------------------------------------
module tb_generalized_ellipse_radius_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import gel_pkg::*;

  localparam int IDLE_PCT    = 18;
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_WAIT  = PIPE_LAT + 20;
  localparam int PHASE_ITEMS = 200;

  typedef struct packed {
    logic [OUT_W-1:0] radius;
    logic             sat;
  } radius_t;

  // one row of the directed table; typed rows carry their own answer
  typedef struct {
    int               dx;
    int               dy;
    bit               typed;
    logic [OUT_W-1:0] radius;
    logic             sat;
  } drow_t;

  // one register setting: cos, sin, 1/q, p, 1/p
  typedef struct {
    longint cos_v;
    longint sin_v;
    longint iar_v;
    longint p_v;
    longint ip_v;
  } setting_t;

  logic                   clk;
  logic                   rst_n;
  logic                   start;
  logic                   busy;
  logic signed [IN_W-1:0] in_delta_x;
  logic signed [IN_W-1:0] in_delta_y;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_idx;
  logic [CFG_W-1:0]       cfg_wdata;
  logic                   out_valid;
  logic [OUT_W-1:0]       out_radius;
  logic                   out_saturated;

  generalized_ellipse_radius_unit u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_delta_x   (in_delta_x),
    .in_delta_y   (in_delta_y),
    .cfg_we       (cfg_we),
    .cfg_idx      (cfg_idx),
    .cfg_wdata    (cfg_wdata),
    .out_valid    (out_valid),
    .out_radius   (out_radius),
    .out_saturated(out_saturated)
  );

  // 4 ns clock
  always begin
    clk = 1'b1; #2;
    clk = 1'b0; #2;
  end

  // bench copy of the register file
  longint cos_q16, sin_q16;
  longint unsigned iar_q16;
  longint p_q12, ip_q12;

  longint unsigned exp_tab [0:16];   // exp2 rom, q1.30

  radius_t radius_q [$];             // radii still in flight
  int      n_err;
  bit      idle_on;
  int      stall_cnt;

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b   = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v   = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // 2^(f/65536) in q1.30, truncating after each rom product
  function automatic longint unsigned pow2_frac(longint f);
    longint unsigned acc;
    acc = 64'd1 << 30;
    for (int k = 1; k <= 16; k++)
      if (f[16-k]) acc = (acc * exp_tab[k]) >> 30;
    return acc;
  endfunction

  // log2 of v (fb fraction bits) with 16 fraction bits, by repeated squaring
  function automatic longint log2_q16(longint unsigned v, int fb);
    int              pos;
    longint unsigned m;
    longint          frac;
    pos  = 63;
    frac = 0;
    while (!v[pos]) pos--;
    m = (pos >= 30) ? (v >> (pos - 30)) : (v << (30 - pos));
    for (int i = 0; i < 16; i++) begin
      m    = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd1 << 31)) begin
        m    = m >> 1;
        frac = frac | 1;
      end
    end
    return longint'(pos - fb) * 65536 + frac;
  endfunction

  function automatic radius_t ellipse_radius(logic signed [IN_W-1:0] dx,
                                             logic signed [IN_W-1:0] dy);
    longint          x, y, ea, eb, mx, d, e, ie, s, r, t, ip, fp, sh;
    longint unsigned ax, ay, tm, frac_term, m, rad;
    radius_t         res;
    x  = longint'(dx) * cos_q16 + longint'(dy) * sin_q16;
    y  = longint'(dy) * cos_q16 - longint'(dx) * sin_q16;
    ax = (x < 0) ? -x : x;
    ay = ((y < 0) ? -y : y) * iar_q16;
    ea = 0;
    eb = 0;
    res = '0;
    // both coordinates zero: no term at all
    if (ax == 0 && ay == 0) return res;
    if (ax != 0) ea = (p_q12 * log2_q16(ax, FRAC_BITS + 16)) >>> 12;
    if (ay != 0) eb = (p_q12 * log2_q16(ay, FRAC_BITS + 32)) >>> 12;
    if (ay == 0) s = ea;
    else if (ax == 0) s = eb;
    else begin
      // log-domain sum: max + log2(1 + 2^-d)
      mx = (ea > eb) ? ea : eb;
      d  = mx - ((ea > eb) ? eb : ea);
      e  = -d;
      ie = e >>> 16;
      sh = -ie;
      tm = pow2_frac(e - ie * 65536);
      frac_term = (sh < 64) ? (tm >> sh) : 0;
      s = mx + log2_q16((64'd1 << 30) + frac_term, 30);
    end
    r  = (s * ip_q12) >>> 12;
    t  = r + longint'(FRAC_BITS) * 65536;
    ip = t >>> 16;
    fp = t - ip * 65536;
    m  = pow2_frac(fp);
    if (ip >= 32) begin
      res.radius = '1;
      res.sat    = 1'b1;
      return res;
    end
    if (ip >= 30) rad = m << (ip - 30);
    else begin
      sh  = 30 - ip;
      rad = (sh < 64) ? (m >> sh) : 0;
    end
    res.radius = rad[OUT_W-1:0];
    return res;
  endfunction

  // one write, then a quiet cycle so back-to-back writes never overlap
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      REG_COS: cos_q16 = longint'($signed(data[17:0]));
      REG_SIN: sin_q16 = longint'($signed(data[17:0]));
      REG_IAR: iar_q16 = data;
      REG_EXP: p_q12   = data[15:0];
      REG_IEX: ip_q12  = data[14:0];
      default: ;   // unmapped index, write ignored
    endcase
    @(posedge clk);
  endtask

  task automatic apply_setting(setting_t st);
    cfg_write(REG_COS, CFG_W'(st.cos_v));
    cfg_write(REG_SIN, CFG_W'(st.sin_v));
    cfg_write(REG_IAR, CFG_W'(st.iar_v));
    cfg_write(REG_EXP, CFG_W'(st.p_v));
    cfg_write(REG_IEX, CFG_W'(st.ip_v));
  endtask

  // present one offset, idling at random first; returns once accepted
  task automatic send_offset(logic signed [IN_W-1:0] dx, logic signed [IN_W-1:0] dy,
                             bit typed, radius_t typed_res);
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start      <= 1'b1;
    in_delta_x <= dx;
    in_delta_y <= dy;
    do @(posedge clk); while (busy);
    radius_q.push_back(typed ? typed_res : ellipse_radius(dx, dy));
  endtask

  // hold the sender until every transaction in flight has come back
  task automatic drain();
    start <= 1'b0;
    while (radius_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [IN_W-1:0] rand_coord();
    logic signed [IN_W-1:0] v;
    v = IN_W'($urandom);
    case ($urandom_range(9))
      4, 5: v = v >>> $urandom_range(IN_W - 2, 8);   // small offsets
      6:    v = 0;
      7: begin
        case ($urandom_range(4))
          0: v = {1'b0, {(IN_W-1){1'b1}}};
          1: v = {1'b1, {(IN_W-1){1'b0}}};
          2: v = 1;
          3: v = -1;
          default: v = 0;
        endcase
      end
      8, 9: v = v >>> $urandom_range(7, 1);
      default: ;
    endcase
    return v;
  endfunction

  // result checker: the unit cannot hold results off, so every strobe counts
  always @(posedge clk) begin
    radius_t want;
    if (rst_n && out_valid) begin
      if (radius_q.size() == 0) begin
        n_err++;
        if (n_err <= 10)
          $display("unexpected result radius=%h sat=%b", out_radius, out_saturated);
      end else begin
        want = radius_q.pop_front();
        if (want.radius !== out_radius || want.sat !== out_saturated) begin
          n_err++;
          if (n_err <= 10)
            $display("mismatch: radius exp %h got %h, sat exp %b got %b",
                     want.radius, out_radius, want.sat, out_saturated);
        end
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt > STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    drow_t    dtab [$];
    setting_t phases [$];
    radius_t  typed_res;

    rst_n      = 1'b0;
    start      = 1'b0;
    in_delta_x = '0;
    in_delta_y = '0;
    cfg_we     = 1'b0;
    cfg_idx    = '0;
    cfg_wdata  = '0;
    n_err      = 0;
    stall_cnt  = 0;
    idle_on    = 1'b1;

    exp_tab[0] = 64'd1 << 31;
    for (int k = 1; k <= 16; k++) exp_tab[k] = isqrt(exp_tab[k-1] << 30);
    cos_q16 = 65536;
    sin_q16 = 0;
    iar_q16 = 65536;
    p_q12   = 8192;
    ip_q12  = 2048;

    // zero base and unit offsets read straight off the reset settings (p = 2)
    dtab = '{
      '{0, 0, 1, 0, 0},
      '{256, 0, 1, 256, 0},
      '{0, 256, 1, 256, 0},
      '{-256, 0, 1, 256, 0},
      '{0, -256, 1, 256, 0},
      '{524287, 524287, 0, 0, 0},
      '{-524288, -524288, 0, 0, 0},
      '{-524288, 524287, 0, 0, 0},
      '{524287, 0, 0, 0, 0},
      '{0, -524288, 0, 0, 0},
      '{1, 0, 0, 0, 0},
      '{0, 1, 0, 0, 0},
      '{1, 1, 0, 0, 0},
      '{-1, -1, 0, 0, 0},
      '{300, -4000, 0, 0, 0},
      '{768, 1024, 0, 0, 0}
    };

    // settings walked after the directed part, extremes and odd values among them
    phases = '{
      '{65536, 0, 65536, 8192, 2048},
      '{46341, 46341, 131072, 4096, 4096},
      '{-65536, 0, 16777216, 32768, 512},
      '{0, -65536, 65536, 1024, 16384},
      '{-46341, 65536, 3000000, 12288, 1365},
      '{131071, -131072, 33554431, 65535, 32767},   // out of range, used as is
      '{65536, 0, 65536, 0, 0},                     // zero exponents
      '{-1000, 65000, 200000, 2048, 8192}
    };

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dtab[i]) begin
      typed_res.radius = dtab[i].radius;
      typed_res.sat    = dtab[i].sat;
      send_offset(IN_W'(dtab[i].dx), IN_W'(dtab[i].dy), dtab[i].typed, typed_res);
    end
    drain();

    // writes past the register list must leave the settings alone
    cfg_write(3'd5, CFG_W'($urandom));
    cfg_write(3'd7, CFG_W'($urandom));

    foreach (phases[ph]) begin
      drain();
      apply_setting(phases[ph]);
      idle_on = (ph != 2);   // one phase at full rate
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 1 && n == 100) drain();
        send_offset(rand_coord(), rand_coord(), 1'b0, '0);
      end
    end

    drain();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (n_err == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
